[rtl/core/bilres_pkg.sv]
// Shared types and constants for the bilinear resize block with tent prefilter.
// Used by every module in rtl/core; depends on nothing else.
package bilres_pkg;

  localparam int OP_W       = 2;
  localparam int COORD_W    = 8;
  localparam int SMP_W      = 16;
  localparam int SIZE_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int WORK_W     = 24;
  localparam int STORE_AW   = 2 * COORD_W;
  localparam int LB_AW      = COORD_W + 1;

  localparam int DIV_NW = 56;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = 6;

  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 56;

  localparam logic [SIZE_W-1:0] MAX_SIZE    = 9'd256;
  localparam logic [23:0]       SCALE_FLOOR = 24'd655;
  localparam logic [22:0]       RQ_MAX      = 23'd6619135;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_X     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_Y     = 3'd7;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_QDIV,
    ST_QWAIT,
    ST_RDIV,
    ST_RWAIT,
    ST_NORM1,
    ST_NORM2,
    ST_NORM3,
    ST_LOAD,
    ST_LDRAIN,
    ST_TAP,
    ST_TDRAIN,
    ST_TDIV,
    ST_TWAIT,
    ST_LERP0,
    ST_LERP1,
    ST_LERP2,
    ST_DONE
  } state_t;

endpackage

[rtl/core/bilres_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on bilres_pkg for its widths.
module bilres_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [bilres_pkg::DIV_NW-1:0] num,
  input  logic [bilres_pkg::DIV_DW-1:0] den,
  output logic                          busy,
  output logic                          done,
  output logic [bilres_pkg::DIV_NW-1:0] quot,
  output logic [bilres_pkg::DIV_DW-1:0] rem
);
  import bilres_pkg::*;

  logic              busy_r, done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r, den_r;
  logic [DIV_DW:0]   trial;
  logic              ge;
  logic [DIV_DW-1:0] rem_nxt;

  assign trial   = {rem_r, q_r[DIV_NW-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[DIV_NW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

[rtl/core/bilres_mac.sv]
// Shared signed multiplier with a registered product and an accumulator behind it.
// Depends on bilres_pkg for widths and the control struct.
module bilres_mac (
  input  logic                                clk,
  input  logic signed [bilres_pkg::MUL_W-1:0]  a,
  input  logic signed [bilres_pkg::MUL_W-1:0]  b,
  input  bilres_pkg::mac_ctl_t                 ctl,
  output logic signed [bilres_pkg::PROD_W-1:0] prod,
  output logic signed [bilres_pkg::ACC_W-1:0]  acc
);
  import bilres_pkg::*;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_nxt = a * b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl.en) begin
      acc_r <= (ctl.clr ? '0 : acc_r) + prod_ext;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

[rtl/core/bilinear_resize_with_tent_prefilter.sv]
// Bilinear resize with tent prefilter: sample stores, line buffer and pass sequencer.
// Write: stores the sample, no result. Read: result strobe in the cycle after the transfer.
// Run: per pass one divide, plus a second one and the NORM1 to NORM3 steps when filtering;
// per line a load, tent taps plus a divide per sample when filtering, LERP0-LERP2 per output.
// done strobes from out_done_r, registered from the DONE state after the last output; no stall.
// Sync active-low reset clears control and config (256 sizes, scale 1.0, crop 0), not stores.
module bilinear_resize_with_tent_prefilter (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [bilres_pkg::OP_W-1:0]             in_op,
  input  logic [bilres_pkg::COORD_W-1:0]          in_col,
  input  logic [bilres_pkg::COORD_W-1:0]          in_row,
  input  logic signed [bilres_pkg::SMP_W-1:0]     in_sample,
  output logic                                    out_strobe,
  output logic signed [bilres_pkg::SMP_W-1:0]     out_sample,
  output logic                                    out_done_res,
  input  logic                                    cfg_we,
  input  logic [bilres_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bilres_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import bilres_pkg::*;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] in_width_r, in_height_r, out_width_r, out_height_r;
  logic [23:0]       scale_x_r, scale_y_r;
  logic [16:0]       crop_x_r, crop_y_r;

  logic [SIZE_W-1:0] w_r, h_r, tw_r, th_r;
  logic              pass_r;
  logic [SIZE_W-1:0] ln_r, cnt_r;
  logic [6:0]        tap_r;
  logic [40:0]       posq_r;
  logic [23:0]       prem_r, r0_r;
  logic [32:0]       q0_r;
  logic [22:0]       rq_r;
  logic [31:0]       norm_r;
  logic              tsign_r;

  logic               ld_v_r;
  logic [7:0]         ld_idx_r;
  logic               tv1_r, tf1_r, tv2_r, tf2_r;
  logic [6:0]         tr1_r;
  logic [16:0]        w1_r;
  logic signed [23:0] p1_r;
  logic               out_strobe_r, out_done_r;

  logic signed [SMP_W-1:0]  is_mem [0:(1<<STORE_AW)-1];
  logic [WORK_W-1:0]        wb_mem [0:(1<<STORE_AW)-1];
  logic signed [SMP_W-1:0]  os_mem [0:(1<<STORE_AW)-1];
  logic [WORK_W-1:0]        lb_mem [0:(1<<LB_AW)-1];
  logic signed [SMP_W-1:0]  is_rd_r, os_rd_r;
  logic [WORK_W-1:0]        wb_rd_r, lb_a_r, lb_b_r;

  logic                accept, wr_go, run_go, rd_go;
  logic [STORE_AW-1:0] is_ra, wb_ra, wb_wa, os_wa;
  logic                wb_we, os_we, lb_we;
  logic [WORK_W-1:0]   wb_wd, lb_wd;
  logic signed [SMP_W-1:0] os_wd;
  logic [LB_AW-1:0]    lb_ra, lb_rb, lb_wa;

  logic              div_go, div_busy, div_done;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den, div_rem;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  mac_ctl_t                 mac_ctl;

  logic [SIZE_W-1:0] n_c, m_c, nl_c, nm1_c;
  logic [23:0]       scale_c, se_c, sp_c;
  logic [16:0]       crop_c;
  logic              tent_c;
  logic [6:0]        ir_c;
  logic [42:0]       crop_q16, xs_c;
  logic [23:0]       top_c, xc_c;
  logic [7:0]        id0_c, id1_c;
  logic              last_c;
  logic [16:0]       lw_c;
  logic [7:0]        p8, lo_c, hi_c;
  logic [8:0]        hi9;
  logic [22:0]       weight_c;
  logic signed [MUL_W-1:0] sum_c, diff_c;
  logic [ACC_W-1:0]  amag_c;
  logic [23:0]       tq_c, tval_c;
  logic [22:0]       rq_c;
  logic signed [PROD_W-1:0] val_c;
  logic              vneg;
  logic [PROD_W-1:0] vmag, rh, rv;
  logic [23:0]       qh, hval;
  logic [27:0]       qv;
  logic signed [SMP_W-1:0] sat_c;
  logic [24:0]       psum;
  logic              pwrap;
  logic              cnt_last, ln_last, m_last;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    if (v > MAX_SIZE) r = MAX_SIZE;
    return r;
  endfunction

  assign accept = start & ~busy;
  assign wr_go  = accept && (in_op == OP_WRITE);
  assign run_go = accept && (in_op == OP_RUN);
  assign rd_go  = accept && (in_op == OP_READ);
  assign busy   = (state_r != ST_IDLE);

  // Per-pass geometry
  assign n_c     = pass_r ? h_r : w_r;
  assign m_c     = pass_r ? th_r : tw_r;
  assign nl_c    = pass_r ? tw_r : h_r;
  assign nm1_c   = n_c - SIZE_W'(1);
  assign scale_c = pass_r ? scale_y_r : scale_x_r;
  assign crop_c  = pass_r ? crop_y_r : crop_x_r;
  assign tent_c  = (scale_c[23:16] == 8'd0);
  assign se_c    = (scale_c == 24'd0) ? 24'd1 : scale_c;
  assign sp_c    = (scale_c < SCALE_FLOOR) ? SCALE_FLOOR : scale_c;
  assign ir_c    = rq_r[22:16];

  assign cnt_last = (cnt_r == nm1_c);
  assign m_last   = (cnt_r == m_c - SIZE_W'(1));
  assign ln_last  = (ln_r == nl_c - SIZE_W'(1));

  // Sample position, clamped to the line
  assign crop_q16 = {{18{crop_c[16]}}, crop_c, 8'h00};
  assign xs_c     = {2'b00, posq_r} + crop_q16;
  assign top_c    = {nm1_c[7:0], 16'h0000};
  always_comb begin
    if (xs_c[42]) begin
      xc_c = '0;
    end else if (xs_c[41:0] > {18'b0, top_c}) begin
      xc_c = top_c;
    end else begin
      xc_c = xs_c[23:0];
    end
  end
  assign id0_c  = xc_c[23:16];
  assign last_c = (id0_c == nm1_c[7:0]);
  assign id1_c  = last_c ? id0_c : id0_c + 8'd1;
  assign lw_c   = last_c ? 17'd0 : 17'h10000 - {1'b0, xc_c[15:0]};

  // Tent tap addresses, clamped to the line ends
  assign p8   = cnt_r[7:0];
  assign lo_c = ({1'b0, tap_r} > p8) ? 8'd0 : p8 - {1'b0, tap_r};
  assign hi9  = {1'b0, p8} + {2'b00, tap_r};
  assign hi_c = (hi9 > nm1_c) ? nm1_c[7:0] : hi9[7:0];

  assign weight_c = {ir_c - tr1_r, rq_r[15:0]};
  assign sum_c    = tf1_r ? MUL_W'($signed(lb_a_r))
                          : MUL_W'($signed(lb_a_r)) + MUL_W'($signed(lb_b_r));
  assign diff_c   = MUL_W'($signed(lb_a_r)) - MUL_W'($signed(lb_b_r));

  assign amag_c = (acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc)) + {25'b0, norm_r[31:1]};
  assign tq_c   = div_quot[23:0];
  assign tval_c = tsign_r ? -tq_c : tq_c;
  assign rq_c   = (div_quot > {33'b0, RQ_MAX}) ? RQ_MAX : div_quot[22:0];

  // Lerp value and its rounding
  assign val_c = prod + $signed({{12{p1_r[23]}}, p1_r, 16'h0000});
  assign vneg  = val_c[PROD_W-1];
  assign vmag  = vneg ? PROD_W'(-val_c) : PROD_W'(val_c);
  assign rh    = vmag + PROD_W'(52'h8000);
  assign qh    = rh[39:16];
  assign hval  = vneg ? -qh : qh;
  assign rv    = vmag + PROD_W'(52'h80_0000);
  assign qv    = rv[51:24];
  always_comb begin
    if (!vneg && qv > 28'd32767) begin
      sat_c = 16'sh7fff;
    end else if (vneg && qv > 28'd32768) begin
      sat_c = 16'sh8000;
    end else begin
      sat_c = vneg ? -$signed(qv[15:0]) : $signed(qv[15:0]);
    end
  end

  assign psum  = {1'b0, prem_r} + {1'b0, r0_r};
  assign pwrap = psum >= {1'b0, se_c};

  assign is_ra = {ln_r[7:0], cnt_r[7:0]};
  assign wb_ra = {cnt_r[7:0], ln_r[7:0]};

  assign mac_ctl.en  = tv2_r;
  assign mac_ctl.clr = tf2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_go    = 1'b0;
    div_num   = 56'h0000_0001_0000_0000;
    div_den   = {8'h00, se_c};
    lb_ra     = {tent_c, id0_c};
    lb_rb     = {tent_c, id1_c};
    lb_we     = 1'b0;
    lb_wa     = {1'b1, cnt_r[7:0]};
    lb_wd     = tval_c;
    wb_we     = 1'b0;
    wb_wa     = {ln_r[7:0], cnt_r[7:0]};
    wb_wd     = hval;
    os_we     = 1'b0;
    os_wa     = {cnt_r[7:0], ln_r[7:0]};
    os_wd     = sat_c;
    mul_a     = {3'b000, weight_c};
    mul_b     = sum_c;
    case (state_r)
      ST_IDLE: begin
        if (run_go) state_nxt = ST_QDIV;
      end
      ST_QDIV: begin
        div_go    = 1'b1;
        state_nxt = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (div_done) state_nxt = tent_c ? ST_RDIV : ST_LOAD;
      end
      ST_RDIV: begin
        div_go    = 1'b1;
        div_den   = {8'h00, sp_c};
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (div_done) state_nxt = ST_NORM1;
      end
      ST_NORM1: begin
        mul_a     = {18'b0, ir_c, 1'b1};
        mul_b     = {3'b000, rq_r};
        state_nxt = ST_NORM2;
      end
      ST_NORM2: begin
        mul_a     = {19'b0, ir_c};
        mul_b     = {18'b0, {1'b0, ir_c} + 8'd1};
        state_nxt = ST_NORM3;
      end
      ST_NORM3: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (cnt_last) state_nxt = ST_LDRAIN;
      end
      ST_LDRAIN: begin
        state_nxt = tent_c ? ST_TAP : ST_LERP0;
      end
      ST_TAP: begin
        lb_ra = {1'b0, lo_c};
        lb_rb = {1'b0, hi_c};
        if (tap_r == ir_c) state_nxt = ST_TDRAIN;
      end
      ST_TDRAIN: begin
        if (!tv1_r && !tv2_r) state_nxt = ST_TDIV;
      end
      ST_TDIV: begin
        div_go    = 1'b1;
        div_num   = amag_c;
        div_den   = norm_r;
        state_nxt = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (div_done) begin
          lb_we     = 1'b1;
          state_nxt = cnt_last ? ST_LERP0 : ST_TAP;
        end
      end
      ST_LERP0: begin
        state_nxt = ST_LERP1;
      end
      ST_LERP1: begin
        mul_a     = {9'b0, w1_r};
        mul_b     = diff_c;
        state_nxt = ST_LERP2;
      end
      ST_LERP2: begin
        wb_we = ~pass_r;
        os_we = pass_r;
        if (m_last) begin
          if (ln_last) begin
            state_nxt = pass_r ? ST_DONE : ST_QDIV;
          end else begin
            state_nxt = ST_LOAD;
          end
        end else begin
          state_nxt = ST_LERP0;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Line load write-back takes the buffer write port
    if (ld_v_r) begin
      lb_we = 1'b1;
      lb_wa = {1'b0, ld_idx_r};
      lb_wd = pass_r ? wb_rd_r : {is_rd_r, 8'h00};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r   <= MAX_SIZE;
      in_height_r  <= MAX_SIZE;
      out_width_r  <= MAX_SIZE;
      out_height_r <= MAX_SIZE;
      scale_x_r    <= 24'h01_0000;
      scale_y_r    <= 24'h01_0000;
      crop_x_r     <= '0;
      crop_y_r     <= '0;
      pass_r       <= 1'b0;
      ln_r         <= '0;
      cnt_r        <= '0;
      tap_r        <= '0;
      ld_v_r       <= 1'b0;
      tv1_r        <= 1'b0;
      tv2_r        <= 1'b0;
      out_strobe_r <= 1'b0;
      out_done_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IN_WIDTH:   in_width_r   <= cfg_data[SIZE_W-1:0];
          CFG_IN_HEIGHT:  in_height_r  <= cfg_data[SIZE_W-1:0];
          CFG_OUT_WIDTH:  out_width_r  <= cfg_data[SIZE_W-1:0];
          CFG_OUT_HEIGHT: out_height_r <= cfg_data[SIZE_W-1:0];
          CFG_SCALE_X:    scale_x_r    <= cfg_data;
          CFG_SCALE_Y:    scale_y_r    <= cfg_data;
          CFG_CROP_X:     crop_x_r     <= cfg_data[16:0];
          CFG_CROP_Y:     crop_y_r     <= cfg_data[16:0];
          default: ;
        endcase
      end
      ld_v_r       <= (state_r == ST_LOAD);
      tv1_r        <= (state_r == ST_TAP);
      tv2_r        <= tv1_r;
      out_strobe_r <= rd_go || (state_r == ST_DONE);
      out_done_r   <= (state_r == ST_DONE);
      if (run_go) pass_r <= 1'b0;
      case (state_r)
        ST_QDIV: begin
          cnt_r <= '0;
          ln_r  <= '0;
        end
        ST_LOAD:   cnt_r <= cnt_r + SIZE_W'(1);
        ST_LDRAIN: begin
          cnt_r <= '0;
          tap_r <= '0;
        end
        ST_TAP:    tap_r <= tap_r + 7'd1;
        ST_TWAIT: begin
          if (div_done) begin
            cnt_r <= cnt_last ? '0 : cnt_r + SIZE_W'(1);
            tap_r <= '0;
          end
        end
        ST_LERP2: begin
          if (m_last) begin
            cnt_r <= '0;
            ln_r  <= ln_r + SIZE_W'(1);
            if (ln_last) pass_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r + SIZE_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (run_go) begin
      w_r  <= clamp_size(in_width_r);
      h_r  <= clamp_size(in_height_r);
      tw_r <= clamp_size(out_width_r);
      th_r <= clamp_size(out_height_r);
    end
    ld_idx_r <= cnt_r[7:0];
    tf1_r    <= (tap_r == 7'd0);
    tr1_r    <= tap_r;
    tf2_r    <= tf1_r;
    case (state_r)
      ST_QWAIT: begin
        if (div_done) begin
          q0_r <= div_quot[32:0];
          r0_r <= div_rem[23:0];
        end
      end
      ST_RWAIT: if (div_done) rq_r <= rq_c;
      ST_NORM2: norm_r <= prod[31:0];
      ST_NORM3: norm_r <= norm_r - {prod[15:0], 16'h0000};
      ST_TDIV:  tsign_r <= acc[ACC_W-1];
      ST_LDRAIN: begin
        posq_r <= '0;
        prem_r <= '0;
      end
      ST_LERP0: w1_r <= lw_c;
      ST_LERP1: p1_r <= $signed(lb_b_r);
      ST_LERP2: begin
        // Advance the exact position i * 2^32 / scale by its quotient and remainder
        prem_r <= pwrap ? 24'(psum - {1'b0, se_c}) : psum[23:0];
        posq_r <= posq_r + {8'h00, q0_r} + {40'b0, pwrap};
      end
      default: ;
    endcase
  end

  // Sample stores
  always_ff @(posedge clk) begin
    if (wr_go) is_mem[{in_row, in_col}] <= in_sample;
    is_rd_r <= is_mem[is_ra];
  end

  always_ff @(posedge clk) begin
    if (wb_we) wb_mem[wb_wa] <= wb_wd;
    wb_rd_r <= wb_mem[wb_ra];
  end

  always_ff @(posedge clk) begin
    if (os_we) os_mem[os_wa] <= os_wd;
    if (rd_go) os_rd_r <= os_mem[{in_row, in_col}];
  end

  // Line buffer: lower bank holds the loaded line, upper bank the tent output
  always_ff @(posedge clk) begin
    if (lb_we) lb_mem[lb_wa] <= lb_wd;
    lb_a_r <= lb_mem[lb_ra];
    lb_b_r <= lb_mem[lb_rb];
  end

  bilres_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  bilres_mac u_mac (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .ctl  (mac_ctl),
    .prod (prod),
    .acc  (acc)
  );

  assign out_strobe   = out_strobe_r;
  assign out_done_res = out_done_r;
  assign out_sample   = out_done_r ? '0 : os_rd_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |-> !div_busy)
    else $error("divider started while busy");

  a_load_wb: assert property (@(posedge clk) disable iff (!rst_n)
    ld_v_r |-> (state_r == ST_LOAD || state_r == ST_LDRAIN))
    else $error("line load write-back outside load");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LERP0) |-> (id0_c <= nm1_c[7:0]))
    else $error("sample position beyond line");

  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_done_res) |-> $past(state_r == ST_DONE))
    else $error("done without finished run");

endmodule
